>>> design/i2cmbs_pkg.sv
// Shared constants and types for the I2C master byte sequencer.
// No dependencies.
package i2cmbs_pkg;

    localparam int unsigned DELAY_W        = 16;
    localparam int unsigned WAIT_W         = 26;
    localparam int unsigned ACTION_W       = 3;
    localparam int unsigned CFG_IDX_W      = 1;
    localparam int unsigned DEF_TICKS_PER_MS = 1000;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;
    localparam logic [WAIT_W-1:0]  WAIT_MAX    = {WAIT_W{1'b1}};

    // Input request codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_IS_MS  = 1'd1;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

endpackage

>>> design/i2c_master_byte_sequencer.sv
// I2C master byte sequencer: open-drain SCL/SDA timing from tick requests.
// Depends on i2cmbs_pkg.
//
// Usage: each request on the s_ channel is either a tick (one microsecond of
// line time) or a command (start, stop, write byte, read byte) given while
// idle. Commands arriving while busy are dropped. Every request yields one
// result on the m_ channel: SCL/SDA release levels, busy, done, last ack and
// last read byte, all as they stand after that request.
// The result is registered and shows in the cycle after its request; one
// request is taken per cycle, set by the single next-state stage feeding the
// result register. The result register frees up as it is taken, so s_ready
// stays high while the receiver takes each result; when m_ready is low with a
// result held, s_ready drops and the state does not move.
// Each wait is delay_count ticks (0 counts as 1), times TICKS_PER_MS in
// millisecond mode, saturated at 2^26-1.
// Reset: both lines released, idle, delay_count 5, microsecond mode,
// ack and read byte cleared.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx;
// write only while idle.
module i2c_master_byte_sequencer #(
    parameter int unsigned TICKS_PER_MS = i2cmbs_pkg::DEF_TICKS_PER_MS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [i2cmbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [i2cmbs_pkg::DELAY_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [i2cmbs_pkg::ACTION_W-1:0]    s_action,
    input  logic [7:0]                         s_byte_value,
    input  logic                               s_sda_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_scl_release,
    output logic                               m_sda_release,
    output logic                               m_busy_res,
    output logic                               m_done_res,
    output logic                               m_ack_received,
    output logic [7:0]                         m_read_data
);

    localparam int unsigned DELAY_W = i2cmbs_pkg::DELAY_W;
    localparam int unsigned WAIT_W  = i2cmbs_pkg::WAIT_W;
    localparam int unsigned TPM_W   = $clog2(TICKS_PER_MS + 1);
    localparam int unsigned PROD_W  = DELAY_W + TPM_W;
    localparam int unsigned CMP_W   = (PROD_W > WAIT_W) ? PROD_W : WAIT_W;
    localparam logic [TPM_W-1:0] TPM_VAL = TPM_W'(TICKS_PER_MS);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2,
        PH_WA, PH_WB, PH_WC, PH_KA, PH_KB, PH_KC, PH_RA, PH_RB
    } phase_t;

    // config
    logic [DELAY_W-1:0] delay_reg;
    logic               unit_ms_reg;

    // sequencer state
    phase_t             phase_reg, phase_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [7:0]         shift_reg, shift_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         rx_reg, rx_next;
    logic               ack_reg, ack_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    i2cmbs_pkg::cmd_t   cmd_reg, cmd_next;
    logic               done_next;

    // result register
    logic               m_valid_reg;
    logic               m_scl_reg, m_sda_reg, m_busy_reg, m_done_reg, m_ack_reg;
    logic [7:0]         m_rx_reg;

    logic               accept;
    logic [DELAY_W-1:0] delay_eff;
    logic [PROD_W-1:0]  prod;
    logic [CMP_W-1:0]   prod_ext;
    logic [WAIT_W-1:0]  wait_load;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // wait length from config
    always_comb begin
        delay_eff = (delay_reg == '0) ? DELAY_W'(1) : delay_reg;
        prod      = PROD_W'(delay_eff) * PROD_W'(TPM_VAL);
        prod_ext  = CMP_W'(prod);
        if (!unit_ms_reg) begin
            wait_load = WAIT_W'(delay_eff);
        end else if (prod_ext > CMP_W'(i2cmbs_pkg::WAIT_MAX)) begin
            wait_load = i2cmbs_pkg::WAIT_MAX;
        end else begin
            wait_load = prod_ext[WAIT_W-1:0];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        rx_next    = rx_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        cmd_next   = cmd_reg;
        done_next  = 1'b0;

        if (phase_reg == PH_IDLE) begin
            case (s_action)
                i2cmbs_pkg::ACT_START: begin
                    cmd_next   = i2cmbs_pkg::CMD_START;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    wait_next  = wait_load;
                    phase_next = PH_ST1;
                end
                i2cmbs_pkg::ACT_STOP: begin
                    cmd_next   = i2cmbs_pkg::CMD_STOP;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    wait_next  = wait_load;
                    phase_next = PH_SP1;
                end
                i2cmbs_pkg::ACT_WRITE, i2cmbs_pkg::ACT_READ: begin
                    if (s_action == i2cmbs_pkg::ACT_READ) begin
                        cmd_next   = i2cmbs_pkg::CMD_READ;
                        rx_next    = '0;
                        shift_next = s_byte_value | 8'h01;
                    end else begin
                        cmd_next   = i2cmbs_pkg::CMD_WRITE;
                        shift_next = s_byte_value;
                    end
                    scl_next   = 1'b0;
                    bit_next   = '0;
                    wait_next  = wait_load;
                    phase_next = PH_WA;
                end
                default: ;
            endcase
        end else if (s_action == i2cmbs_pkg::ACT_TICK) begin
            if (wait_reg > WAIT_W'(1)) begin
                wait_next = wait_reg - WAIT_W'(1);
            end else begin
                // end of wait: step the line sequence
                wait_next = wait_load;
                unique case (phase_reg)
                    PH_ST1: begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST2;
                    end
                    PH_SP1: begin
                        scl_next   = 1'b1;
                        phase_next = PH_SP2;
                    end
                    PH_WA: begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_WB;
                    end
                    PH_WB: begin
                        scl_next   = 1'b1;
                        phase_next = PH_WC;
                    end
                    PH_WC: begin
                        scl_next = 1'b0;
                        bit_next = bit_reg + 4'd1;
                        if (bit_next < 4'd8) begin
                            sda_next   = 1'b0;
                            phase_next = PH_WA;
                        end else begin
                            sda_next   = 1'b1;
                            phase_next = PH_KA;
                        end
                    end
                    PH_KA: begin
                        scl_next   = 1'b1;
                        phase_next = PH_KB;
                    end
                    PH_KB: begin
                        ack_next   = !s_sda_sample;
                        scl_next   = 1'b0;
                        phase_next = PH_KC;
                    end
                    PH_KC: begin
                        if (cmd_reg == i2cmbs_pkg::CMD_READ && ack_reg) begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            bit_next   = '0;
                            phase_next = PH_RA;
                        end else begin
                            done_next  = 1'b1;
                        end
                    end
                    PH_RA: begin
                        scl_next   = 1'b1;
                        phase_next = PH_RB;
                    end
                    PH_RB: begin
                        if (s_sda_sample) begin
                            rx_next[3'd7 - bit_reg[2:0]] = 1'b1;
                        end
                        scl_next = 1'b0;
                        bit_next = bit_reg + 4'd1;
                        if (bit_next < 4'd8) begin
                            phase_next = PH_RA;
                        end else begin
                            done_next  = 1'b1;
                        end
                    end
                    PH_ST2: begin
                        scl_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    PH_SP2: begin
                        sda_next  = 1'b1;
                        done_next = 1'b1;
                    end
                    default: begin
                        done_next = 1'b1;
                    end
                endcase
                if (done_next) begin
                    phase_next = PH_IDLE;
                    wait_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= i2cmbs_pkg::DELAY_RESET;
            unit_ms_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            wait_reg    <= '0;
            shift_reg   <= '0;
            bit_reg     <= '0;
            rx_reg      <= '0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            cmd_reg     <= i2cmbs_pkg::CMD_START;
            m_valid_reg <= 1'b0;
            m_scl_reg   <= 1'b1;
            m_sda_reg   <= 1'b1;
            m_busy_reg  <= 1'b0;
            m_done_reg  <= 1'b0;
            m_ack_reg   <= 1'b0;
            m_rx_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    i2cmbs_pkg::REG_DELAY_COUNT: delay_reg   <= cfg_wdata;
                    i2cmbs_pkg::REG_UNIT_IS_MS:  unit_ms_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg   <= phase_next;
                wait_reg    <= wait_next;
                shift_reg   <= shift_next;
                bit_reg     <= bit_next;
                rx_reg      <= rx_next;
                ack_reg     <= ack_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                cmd_reg     <= cmd_next;
                m_valid_reg <= 1'b1;
                m_scl_reg   <= scl_next;
                m_sda_reg   <= sda_next;
                m_busy_reg  <= (phase_next != PH_IDLE);
                m_done_reg  <= done_next;
                m_ack_reg   <= ack_next;
                m_rx_reg    <= rx_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_release  = m_scl_reg;
    assign m_sda_release  = m_sda_reg;
    assign m_busy_res     = m_busy_reg;
    assign m_done_res     = m_done_reg;
    assign m_ack_received = m_ack_reg;
    assign m_read_data    = m_rx_reg;

    // a running sequence always has a wait pending
    a_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> wait_reg != '0)
        else $error("busy with empty wait counter");

    a_idle_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> wait_reg == '0)
        else $error("idle with nonzero wait counter");

    // data phase only reached by an acknowledged read
    a_read_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RA || phase_reg == PH_RB) |->
            (cmd_reg == i2cmbs_pkg::CMD_READ && ack_reg))
        else $error("read data phase without acked read");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> !m_busy_reg)
        else $error("done result still busy");

endmodule

>>> tb/tb.sv
// Self-checking testbench for i2c_master_byte_sequencer: a request-level line predictor
// runs beside the block and every result is compared field by field.
// Depends on i2cmbs_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICKS     = i2cmbs_pkg::DEF_TICKS_PER_MS;
    localparam int unsigned ACTION_W  = i2cmbs_pkg::ACTION_W;
    localparam int unsigned CFG_IDX_W = i2cmbs_pkg::CFG_IDX_W;
    localparam int unsigned DELAY_W   = i2cmbs_pkg::DELAY_W;
    localparam int unsigned WAIT_W    = i2cmbs_pkg::WAIT_W;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B,
        PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW,
        PH_ACK_RISE, PH_ACK_SAMPLE, PH_ACK_END,
        PH_RD_HIGH, PH_RD_SAMPLE
    } line_phase_t;

    typedef enum int {FILL_ZEROS, FILL_ONES, FILL_RANDOM} rd_fill_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rdata;
    } line_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = i2cmbs_pkg::REG_DELAY_COUNT;
    logic [DELAY_W-1:0]    cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ACTION_W-1:0]   s_action = i2cmbs_pkg::ACT_TICK;
    logic [7:0]            s_byte_value = '0;
    logic                  s_sda_sample = 1'b1;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_scl_release;
    logic                  m_sda_release;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic                  m_ack_received;
    logic [7:0]            m_read_data;

    // predicted line state and configuration
    line_phase_t           line_phase;
    logic [WAIT_W-1:0]     wait_left;
    logic [7:0]            tx_shift;
    logic [3:0]            bit_cnt;
    logic [7:0]            rx_byte;
    logic                  ack_seen;
    logic                  scl_rel;
    logic                  sda_rel;
    i2cmbs_pkg::cmd_t      active_cmd;
    logic [DELAY_W-1:0]    delay_units;
    logic                  ms_mode;

    line_result_t          line_results[$];
    line_result_t          want;
    int                    mismatch_cnt = 0;
    int                    useful_cnt = 0;
    int                    send_idle_pct = 0;
    int                    ready_stall_pct = 0;

    i2c_master_byte_sequencer #(.TICKS_PER_MS(TICKS)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_byte_value   (s_byte_value),
        .s_sda_sample   (s_sda_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_release  (m_scl_release),
        .m_sda_release  (m_sda_release),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_ack_received (m_ack_received),
        .m_read_data    (m_read_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // ---------------- line predictor ----------------

    function automatic void clear_line_state();
        line_phase  = PH_IDLE;
        wait_left   = '0;
        tx_shift    = '0;
        bit_cnt     = '0;
        rx_byte     = '0;
        ack_seen    = 1'b0;
        scl_rel     = 1'b1;
        sda_rel     = 1'b1;
        active_cmd  = i2cmbs_pkg::CMD_START;
        delay_units = i2cmbs_pkg::DELAY_RESET;
        ms_mode     = 1'b0;
    endfunction

    function automatic void arm_wait(line_phase_t nxt);
        longint unsigned w;
        w = (delay_units == '0) ? 1 : delay_units;
        if (ms_mode)
            w = w * TICKS;
        if (w > i2cmbs_pkg::WAIT_MAX)
            w = i2cmbs_pkg::WAIT_MAX;
        wait_left  = WAIT_W'(w);
        line_phase = nxt;
    endfunction

    function automatic void start_byte(logic [7:0] val);
        scl_rel  = 1'b0;
        tx_shift = val;
        bit_cnt  = '0;
        arm_wait(PH_BIT_SETUP);
    endfunction

    // line changes at the end of a wait; returns 1 when the command completes
    function automatic logic wait_expired(logic sda_in);
        logic finished;
        finished = 1'b0;
        case (line_phase)
            PH_START_A: begin
                sda_rel = 1'b0;
                arm_wait(PH_START_B);
            end
            PH_START_B: begin
                scl_rel = 1'b0;
                finished = 1'b1;
            end
            PH_STOP_A: begin
                scl_rel = 1'b1;
                arm_wait(PH_STOP_B);
            end
            PH_STOP_B: begin
                sda_rel = 1'b1;
                finished = 1'b1;
            end
            PH_BIT_SETUP: begin
                sda_rel  = tx_shift[7];
                tx_shift = tx_shift << 1;
                arm_wait(PH_BIT_HIGH);
            end
            PH_BIT_HIGH: begin
                scl_rel = 1'b1;
                arm_wait(PH_BIT_LOW);
            end
            PH_BIT_LOW: begin
                scl_rel = 1'b0;
                sda_rel = 1'b0;
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < 8) begin
                    arm_wait(PH_BIT_SETUP);
                end else begin
                    sda_rel = 1'b1;
                    arm_wait(PH_ACK_RISE);
                end
            end
            PH_ACK_RISE: begin
                scl_rel = 1'b1;
                arm_wait(PH_ACK_SAMPLE);
            end
            PH_ACK_SAMPLE: begin
                ack_seen = ~sda_in;
                scl_rel  = 1'b0;
                arm_wait(PH_ACK_END);
            end
            PH_ACK_END: begin
                if (active_cmd == i2cmbs_pkg::CMD_READ && ack_seen) begin
                    scl_rel = 1'b0;
                    sda_rel = 1'b1;
                    bit_cnt = '0;
                    arm_wait(PH_RD_HIGH);
                end else begin
                    finished = 1'b1;
                end
            end
            PH_RD_HIGH: begin
                scl_rel = 1'b1;
                arm_wait(PH_RD_SAMPLE);
            end
            PH_RD_SAMPLE: begin
                if (sda_in)
                    rx_byte[3'd7 - bit_cnt[2:0]] = 1'b1;
                scl_rel = 1'b0;
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < 8)
                    arm_wait(PH_RD_HIGH);
                else
                    finished = 1'b1;
            end
            default: begin
                finished = 1'b1;
            end
        endcase
        if (finished) begin
            line_phase = PH_IDLE;
            wait_left  = '0;
        end
        return finished;
    endfunction

    function automatic void predict_request(logic [ACTION_W-1:0] act, logic [7:0] val,
                                            logic sda_in);
        logic finished;
        finished = 1'b0;
        if (line_phase == PH_IDLE) begin
            case (act)
                i2cmbs_pkg::ACT_START: begin
                    active_cmd = i2cmbs_pkg::CMD_START;
                    scl_rel = 1'b1;
                    sda_rel = 1'b1;
                    arm_wait(PH_START_A);
                end
                i2cmbs_pkg::ACT_STOP: begin
                    active_cmd = i2cmbs_pkg::CMD_STOP;
                    scl_rel = 1'b0;
                    sda_rel = 1'b0;
                    arm_wait(PH_STOP_A);
                end
                i2cmbs_pkg::ACT_WRITE: begin
                    active_cmd = i2cmbs_pkg::CMD_WRITE;
                    start_byte(val);
                end
                i2cmbs_pkg::ACT_READ: begin
                    active_cmd = i2cmbs_pkg::CMD_READ;
                    rx_byte = '0;
                    start_byte(val | 8'h01);
                end
                default: ;
            endcase
        end else if (act == i2cmbs_pkg::ACT_TICK) begin
            if (wait_left > 1) begin
                wait_left = wait_left - 1'b1;
            end else begin
                wait_left = '0;
                finished = wait_expired(sda_in);
            end
        end
        line_results.push_back('{scl_rel, sda_rel, line_phase != PH_IDLE, finished,
                                  ack_seen, rx_byte});
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want_v);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (line_results.size() == 0) begin
                report_mismatch("unexpected result", m_read_data, 8'h00);
            end else begin
                want = line_results.pop_front();
                if (m_scl_release !== want.scl)
                    report_mismatch("scl_release", 8'(m_scl_release), 8'(want.scl));
                if (m_sda_release !== want.sda)
                    report_mismatch("sda_release", 8'(m_sda_release), 8'(want.sda));
                if (m_busy_res !== want.busy)
                    report_mismatch("busy_res", 8'(m_busy_res), 8'(want.busy));
                if (m_done_res !== want.done)
                    report_mismatch("done_res", 8'(m_done_res), 8'(want.done));
                if (m_ack_received !== want.ack)
                    report_mismatch("ack_received", 8'(m_ack_received), 8'(want.ack));
                if (m_read_data !== want.rdata)
                    report_mismatch("read_data", m_read_data, want.rdata);
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [7:0] val,
                                input logic sda_in);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_byte_value <= val;
        s_sda_sample <= sda_in;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // requests that move the sequencer count toward the random quota
        if ((line_phase == PH_IDLE) ?
                (act inside {[i2cmbs_pkg::ACT_START:i2cmbs_pkg::ACT_READ]}) :
                (act == i2cmbs_pkg::ACT_TICK))
            useful_cnt++;
        predict_request(act, val, sda_in);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (line_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == i2cmbs_pkg::REG_DELAY_COUNT)
            delay_units = data;
        else
            ms_mode = data[0];
    endtask

    // SDA level the slave would present in the current phase
    function automatic logic pick_sda(int ack_pct, rd_fill_t fill);
        if (line_phase == PH_ACK_SAMPLE)
            return $urandom_range(99) >= ack_pct;
        if (line_phase == PH_RD_SAMPLE && fill != FILL_RANDOM)
            return fill == FILL_ONES;
        return 1'($urandom_range(1));
    endfunction

    task automatic run_to_idle(input int ack_pct, input rd_fill_t fill, input int noise_pct);
        logic [ACTION_W-1:0] junk;
        while (line_phase != PH_IDLE) begin
            if ($urandom_range(99) < noise_pct) begin
                // anything but a tick is dropped while busy
                junk = ACTION_W'($urandom_range(i2cmbs_pkg::ACT_START, ACT_UNUSED_HI));
                send_request(junk, 8'($urandom), 1'($urandom));
            end else begin
                send_request(i2cmbs_pkg::ACT_TICK, 8'($urandom), pick_sda(ack_pct, fill));
            end
        end
    endtask

    task automatic issue_command(input logic [ACTION_W-1:0] act, input logic [7:0] val,
                                 input int ack_pct, input rd_fill_t fill, input int noise_pct);
        send_request(act, val, 1'($urandom));
        run_to_idle(ack_pct, fill, noise_pct);
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_request(i2cmbs_pkg::ACT_TICK, 8'h00, 1'b1);
        issue_command(i2cmbs_pkg::ACT_START, 8'h00, 50, FILL_RANDOM, 0);
        issue_command(i2cmbs_pkg::ACT_STOP, 8'hFF, 50, FILL_RANDOM, 0);
    endtask

    task automatic test_directed();
        write_reg(i2cmbs_pkg::REG_UNIT_IS_MS, DELAY_W'(0));
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'(0));
        send_request(i2cmbs_pkg::ACT_TICK, 8'hFF, 1'b0);
        for (int a = i2cmbs_pkg::ACT_READ + 1; a <= ACT_UNUSED_HI; a++)
            send_request(ACTION_W'(a), 8'h00, 1'b1);
        issue_command(i2cmbs_pkg::ACT_START, 8'h00, 50, FILL_RANDOM, 0);
        issue_command(i2cmbs_pkg::ACT_STOP, 8'h00, 50, FILL_RANDOM, 0);
        issue_command(i2cmbs_pkg::ACT_WRITE, 8'h00, 100, FILL_RANDOM, 0);
        issue_command(i2cmbs_pkg::ACT_WRITE, 8'hFF, 0, FILL_RANDOM, 0);
        issue_command(i2cmbs_pkg::ACT_WRITE, 8'hA5, 50, FILL_RANDOM, 30);
        issue_command(i2cmbs_pkg::ACT_READ, 8'hFE, 100, FILL_ONES, 0);
        issue_command(i2cmbs_pkg::ACT_READ, 8'h00, 100, FILL_ZEROS, 0);
        // nacked address clears the previous read byte
        issue_command(i2cmbs_pkg::ACT_READ, 8'h5A, 0, FILL_ONES, 0);
        issue_command(i2cmbs_pkg::ACT_READ, 8'hFF, 100, FILL_RANDOM, 30);
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'(2));
        issue_command(i2cmbs_pkg::ACT_WRITE, 8'h81, 100, FILL_RANDOM, 10);
    endtask

    // one millisecond wait run to its last tick, then back to one-tick waits
    // so the rest of the start sequence is short
    task automatic test_ms_unit();
        write_reg(i2cmbs_pkg::REG_UNIT_IS_MS, DELAY_W'(1));
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'(0));
        send_request(i2cmbs_pkg::ACT_START, 8'h00, 1'b1);
        repeat (TICKS - 1)
            send_request(i2cmbs_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
        write_reg(i2cmbs_pkg::REG_UNIT_IS_MS, DELAY_W'(0));
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'(1));
        run_to_idle(50, FILL_RANDOM, 2);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int n_items);
        int                  first_cnt;
        int                  pick;
        logic [ACTION_W-1:0] act;
        send_idle_pct   = gap_pct;
        ready_stall_pct = stall_pct;
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'($urandom_range(3)));
        first_cnt = useful_cnt;
        while (useful_cnt - first_cnt < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                write_reg(i2cmbs_pkg::REG_DELAY_COUNT, DELAY_W'($urandom_range(4)));
            end else if (pick < 16) begin
                // stray requests while idle: plain ticks and unused codes
                act = $urandom_range(1) ? i2cmbs_pkg::ACT_TICK
                    : ACTION_W'($urandom_range(i2cmbs_pkg::ACT_READ + 1, ACT_UNUSED_HI));
                send_request(act, 8'($urandom), 1'($urandom));
            end else begin
                if (pick < 24)
                    drain_results();
                act = ACTION_W'($urandom_range(i2cmbs_pkg::ACT_START, i2cmbs_pkg::ACT_READ));
                issue_command(act, 8'($urandom), 70, FILL_RANDOM, 5);
            end
        end
    endtask

    // run ends mid-command with the longest millisecond wait loaded
    task automatic test_busy_at_end();
        logic [ACTION_W-1:0] act;
        write_reg(i2cmbs_pkg::REG_UNIT_IS_MS, DELAY_W'(1));
        write_reg(i2cmbs_pkg::REG_DELAY_COUNT, '1);
        send_request(i2cmbs_pkg::ACT_READ, 8'($urandom), 1'($urandom));
        repeat (40) begin
            act = $urandom_range(1) ? i2cmbs_pkg::ACT_TICK
                                    : ACTION_W'($urandom_range(ACT_UNUSED_HI));
            send_request(act, 8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        clear_line_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_directed();
        test_ms_unit();
        test_random_traffic(0, 0, 150);
        test_random_traffic(77, 0, 150);
        test_random_traffic(0, 77, 150);
        test_random_traffic(26, 26, 150);
        test_busy_at_end();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
design/i2cmbs_pkg.sv
design/i2c_master_byte_sequencer.sv
tb/tb.sv
